// ===== hdl/ccc_pkg.sv =====
// Colour card classifier package: opcodes, register indexes, field widths and
// the built-in reference colours and colour-to-command map.
// No dependencies.
`timescale 1ns / 1ps

package ccc_pkg;

    localparam logic [1:0] OP_CLASSIFY = 2'd0;
    localparam logic [1:0] OP_WRITE    = 2'd1;
    localparam logic [1:0] OP_CLEAR    = 2'd2;

    localparam logic [2:0] REG_RATIO        = 3'd0;
    localparam logic [2:0] REG_RATIO_ORANGE = 3'd1;
    localparam logic [2:0] REG_RATIO_YELLOW = 3'd2;
    localparam logic [2:0] REG_RATIO_GREEN  = 3'd3;
    localparam logic [2:0] REG_MARGIN       = 3'd4;
    localparam logic [2:0] REG_BRIGHT       = 3'd5;
    localparam logic [2:0] REG_CHROMA       = 3'd6;

    localparam logic [3:0] SHADE_GRAY   = 4'd0;
    localparam logic [3:0] SHADE_ORANGE = 4'd2;
    localparam logic [3:0] SHADE_YELLOW = 4'd3;
    localparam logic [3:0] SHADE_GREEN  = 4'd4;

    localparam logic [3:0] CMD_NONE = 4'd0;

    localparam int DIV_STEPS = 35;
    localparam int IN_DATA_W = 104;
    localparam int IN_USER_W = 3;
    localparam int OUT_DATA_W = 24;
    localparam int CFG_W = 18;

    function automatic logic [15:0] default_rgb(input logic [3:0] idx, input logic [1:0] ch);
        logic [47:0] e;
        begin
            case (idx)
                4'd0:    e = {16'd900,  16'd900,  16'd900};
                4'd1:    e = {16'd500,  16'd500,  16'd2000};
                4'd2:    e = {16'd450,  16'd1100, 16'd2200};
                4'd3:    e = {16'd500,  16'd2000, 16'd2200};
                4'd4:    e = {16'd600,  16'd1800, 16'd500};
                4'd5:    e = {16'd2000, 16'd700,  16'd500};
                4'd6:    e = {16'd1800, 16'd600,  16'd1200};
                4'd7:    e = {16'd900,  16'd1900, 16'd1100};
                4'd8:    e = {16'd1900, 16'd1500, 16'd800};
                4'd9:    e = {16'd1300, 16'd900,  16'd2100};
                4'd10:   e = {16'd200,  16'd200,  16'd200};
                4'd11:   e = {16'd2200, 16'd2200, 16'd2200};
                default: e = 48'd0;
            endcase
            case (ch)
                2'd0:    default_rgb = e[15:0];
                2'd1:    default_rgb = e[31:16];
                default: default_rgb = e[47:32];
            endcase
        end
    endfunction

    function automatic logic [3:0] mode_of_color(input logic [3:0] c);
        begin
            case (c)
                4'd1:    mode_of_color = 4'd1;
                4'd2:    mode_of_color = 4'd8;
                4'd3:    mode_of_color = 4'd2;
                4'd4:    mode_of_color = 4'd3;
                4'd5:    mode_of_color = 4'd4;
                4'd6:    mode_of_color = 4'd5;
                4'd8:    mode_of_color = 4'd7;
                4'd9:    mode_of_color = 4'd6;
                default: mode_of_color = CMD_NONE;
            endcase
        end
    endfunction

endpackage

// ===== hdl/color_card_classifier_core.sv =====
// Colour card classifier top level: residual-distance nearest match per side,
// ambiguity gate and command list bookkeeping on one shared multiplier.
// Depends on ccc_pkg.
`timescale 1ns / 1ps

// One item at a time; s_tready is high only while the sequencer is idle.
// A classify item scans NUM_COLORS entries per side through one 35x32
// multiplier and a one-bit-per-cycle divider: each entry takes |ref|^2, the
// cross terms, the division and a compare; a zero entry takes |ref|^2, |v|^2
// and a compare; the ambiguity gate may follow each side. Write, clear and
// unused items skip the scan. The result sits in an output register, so
// the next item is accepted while it waits.
module color_card_classifier_core
    import ccc_pkg::*;
#(
    parameter int NUM_COLORS   = 12,
    parameter int CMD_CAPACITY = 16,
    parameter int SAMPLE_BITS  = 16
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [2:0]            cfg_index,
    input  logic [CFG_W-1:0]      cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // ref_index, left_red, left_green, left_blue, right_red, right_green, right_blue
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // opcode, side
    input  logic [IN_USER_W-1:0]  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // left_color, right_color, agree_valid, current_color, new_command,
    // inserted_command, command_count
    output logic [OUT_DATA_W-1:0] m_tdata
);

    localparam int CW = $clog2(NUM_COLORS);
    localparam int NW = $clog2(CMD_CAPACITY + 1);
    localparam logic [4:0] COLOR_NONE = 5'(NUM_COLORS);

    typedef enum logic [3:0] {
        ST_IDLE, ST_DEN, ST_VSQ, ST_PA, ST_PB, ST_SQ, ST_SUMF, ST_DIV,
        ST_CMP, ST_CHK, ST_G1, ST_G2, ST_G3, ST_G4, ST_FIN
    } state_t;

    state_t state_reg;

    logic [15:0] ratio_reg, ratio_or_reg, ratio_ye_reg, ratio_gr_reg;
    logic [15:0] margin_reg, chroma_reg;
    logic [17:0] bright_reg;

    logic [15:0] tbl_reg [2][NUM_COLORS][3];
    logic [SAMPLE_BITS-1:0] lv_reg [3];
    logic [SAMPLE_BITS-1:0] rv_reg [3];

    logic [1:0]    op_reg;
    logic          side_reg;
    logic [CW-1:0] ent_reg;
    logic [1:0]    k_reg;
    logic [5:0]    cnt_reg;
    logic [66:0]   prod_reg;
    logic [31:0]   a_reg;
    logic [33:0]   den_reg;
    logic [65:0]   num_reg;
    logic [33:0]   rem_reg;
    logic [34:0]   q_reg;
    logic [34:0]   dist_reg;
    logic [34:0]   best_reg, second_reg;
    logic          have_b_reg, have_s_reg;
    logic [3:0]    match_reg;
    logic          fail1_reg, fail2_reg;
    logic [3:0]    lc_reg, rc_reg;
    logic [4:0]    last_reg;
    logic [NW-1:0] count_reg;
    logic          out_valid_reg;
    logic [OUT_DATA_W-1:0] out_reg;

    logic [1:0]  jk;
    logic [15:0] vk, vj, rk, rj;
    logic [34:0] mul_x;
    logic [31:0] mul_y;
    logic [31:0] df;
    logic [33:0] den_next;
    logic [65:0] num_next;
    logic [34:0] trial;
    logic        take;
    logic [15:0] thr;
    logic [17:0] vsum;
    logic [15:0] vmax, vmin;
    logic        gray;
    logic [3:0]  side_color;
    logic [3:0]  lm, rm;

    function automatic logic [15:0] pick_v(input logic s, input logic [1:0] i,
                                           input logic [SAMPLE_BITS-1:0] l0,
                                           input logic [SAMPLE_BITS-1:0] l1,
                                           input logic [SAMPLE_BITS-1:0] l2,
                                           input logic [SAMPLE_BITS-1:0] r0,
                                           input logic [SAMPLE_BITS-1:0] r1,
                                           input logic [SAMPLE_BITS-1:0] r2);
        logic [SAMPLE_BITS-1:0] x;
        begin
            case (i)
                2'd0:    x = s ? r0 : l0;
                2'd1:    x = s ? r1 : l1;
                default: x = s ? r2 : l2;
            endcase
            pick_v = 16'(x);
        end
    endfunction

    always_comb
    begin
        jk = (k_reg == 2'd2) ? 2'd0 : k_reg + 2'd1;
        vk = pick_v(side_reg, k_reg, lv_reg[0], lv_reg[1], lv_reg[2],
                    rv_reg[0], rv_reg[1], rv_reg[2]);
        vj = pick_v(side_reg, jk, lv_reg[0], lv_reg[1], lv_reg[2],
                    rv_reg[0], rv_reg[1], rv_reg[2]);
        rk = tbl_reg[side_reg][ent_reg][k_reg];
        rj = tbl_reg[side_reg][ent_reg][jk];
        df = (a_reg > prod_reg[31:0]) ? a_reg - prod_reg[31:0] : prod_reg[31:0] - a_reg;
        case (match_reg)
            SHADE_ORANGE: thr = ratio_or_reg;
            SHADE_YELLOW: thr = ratio_ye_reg;
            SHADE_GREEN:  thr = ratio_gr_reg;
            default:      thr = ratio_reg;
        endcase
        vsum = 18'(pick_v(side_reg, 2'd0, lv_reg[0], lv_reg[1], lv_reg[2],
                          rv_reg[0], rv_reg[1], rv_reg[2]))
             + 18'(pick_v(side_reg, 2'd1, lv_reg[0], lv_reg[1], lv_reg[2],
                          rv_reg[0], rv_reg[1], rv_reg[2]))
             + 18'(pick_v(side_reg, 2'd2, lv_reg[0], lv_reg[1], lv_reg[2],
                          rv_reg[0], rv_reg[1], rv_reg[2]));
        vmax = pick_v(side_reg, 2'd0, lv_reg[0], lv_reg[1], lv_reg[2],
                      rv_reg[0], rv_reg[1], rv_reg[2]);
        vmin = vmax;
        for (int i = 1; i < 3; i++)
        begin
            if (pick_v(side_reg, 2'(i), lv_reg[0], lv_reg[1], lv_reg[2],
                       rv_reg[0], rv_reg[1], rv_reg[2]) > vmax)
            begin
                vmax = pick_v(side_reg, 2'(i), lv_reg[0], lv_reg[1], lv_reg[2],
                              rv_reg[0], rv_reg[1], rv_reg[2]);
            end
            if (pick_v(side_reg, 2'(i), lv_reg[0], lv_reg[1], lv_reg[2],
                       rv_reg[0], rv_reg[1], rv_reg[2]) < vmin)
            begin
                vmin = pick_v(side_reg, 2'(i), lv_reg[0], lv_reg[1], lv_reg[2],
                              rv_reg[0], rv_reg[1], rv_reg[2]);
            end
        end
        gray = (fail1_reg || fail2_reg)
            && ((vsum < bright_reg)
                || ({2'b00, 16'(vmax - vmin), 16'd0} < prod_reg[33:0]));

        case (state_reg)
            ST_DEN:  begin mul_x = 35'(rk); mul_y = 32'(rk); end
            ST_VSQ:  begin mul_x = 35'(vk); mul_y = 32'(vk); end
            ST_PA:   begin mul_x = 35'(vk); mul_y = 32'(rj); end
            ST_PB:   begin mul_x = 35'(vj); mul_y = 32'(rk); end
            ST_SQ:   begin mul_x = 35'(df); mul_y = df; end
            ST_G1:   begin mul_x = second_reg; mul_y = 32'(thr); end
            ST_G2:   begin mul_x = second_reg; mul_y = 32'(margin_reg); end
            ST_G3:   begin mul_x = 35'(vsum); mul_y = 32'(chroma_reg); end
            default: begin mul_x = '0; mul_y = '0; end
        endcase

        den_next = den_reg + ((k_reg != 2'd0) ? 34'(prod_reg[31:0]) : 34'd0);
        num_next = num_reg + 66'(prod_reg[63:0]);
        trial = {rem_reg, num_reg[34]};
        take = (trial >= 35'(den_reg));
        side_color = (state_reg == ST_G4 && gray) ? SHADE_GRAY : match_reg;
        lm = mode_of_color(lc_reg);
        rm = mode_of_color(rc_reg);
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= 67'(mul_x) * 67'(mul_y);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ratio_reg    <= 16'd55706;
            ratio_or_reg <= 16'd60293;
            ratio_ye_reg <= 16'd60293;
            ratio_gr_reg <= 16'd58982;
            margin_reg   <= 16'd3277;
            bright_reg   <= 18'd150;
            chroma_reg   <= 16'd1311;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_RATIO:        ratio_reg    <= cfg_data[15:0];
                REG_RATIO_ORANGE: ratio_or_reg <= cfg_data[15:0];
                REG_RATIO_YELLOW: ratio_ye_reg <= cfg_data[15:0];
                REG_RATIO_GREEN:  ratio_gr_reg <= cfg_data[15:0];
                REG_MARGIN:       margin_reg   <= cfg_data[15:0];
                REG_BRIGHT:       bright_reg   <= cfg_data;
                REG_CHROMA:       chroma_reg   <= cfg_data[15:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < 2; s++)
                for (int i = 0; i < NUM_COLORS; i++)
                    for (int c = 0; c < 3; c++)
                        tbl_reg[s][i][c] <= default_rgb(4'(i), 2'(c));
        end
        else if (s_tvalid && s_tready && s_tuser[1:0] == OP_WRITE
                 && 5'(s_tdata[3:0]) < 5'(NUM_COLORS))
        begin
            tbl_reg[s_tuser[2]][CW'(s_tdata[3:0])][0] <= 16'(s_tdata[4 +: SAMPLE_BITS]);
            tbl_reg[s_tuser[2]][CW'(s_tdata[3:0])][1] <= 16'(s_tdata[20 +: SAMPLE_BITS]);
            tbl_reg[s_tuser[2]][CW'(s_tdata[3:0])][2] <= 16'(s_tdata[36 +: SAMPLE_BITS]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_CLASSIFY;
            side_reg      <= 1'b0;
            ent_reg       <= '0;
            k_reg         <= 2'd0;
            cnt_reg       <= 6'd0;
            have_b_reg    <= 1'b0;
            have_s_reg    <= 1'b0;
            last_reg      <= COLOR_NONE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        op_reg <= s_tuser[1:0];
                        for (int c = 0; c < 3; c++)
                        begin
                            lv_reg[c] <= s_tdata[4 + 16*c +: SAMPLE_BITS];
                            rv_reg[c] <= s_tdata[52 + 16*c +: SAMPLE_BITS];
                        end
                        side_reg   <= 1'b0;
                        ent_reg    <= '0;
                        k_reg      <= 2'd0;
                        den_reg    <= 34'd0;
                        have_b_reg <= 1'b0;
                        have_s_reg <= 1'b0;
                        state_reg  <= (s_tuser[1:0] == OP_CLASSIFY) ? ST_DEN : ST_FIN;
                    end
                end
                ST_DEN:
                begin
                    den_reg <= den_next;
                    k_reg   <= k_reg + 2'd1;
                    if (k_reg == 2'd3)
                    begin
                        k_reg     <= 2'd0;
                        num_reg   <= 66'd0;
                        state_reg <= (den_next == 34'd0) ? ST_VSQ : ST_PA;
                    end
                end
                ST_VSQ:
                begin
                    if (k_reg != 2'd0)
                    begin
                        num_reg <= num_next;
                    end
                    k_reg <= k_reg + 2'd1;
                    if (k_reg == 2'd3)
                    begin
                        dist_reg  <= num_next[34:0];
                        state_reg <= ST_CMP;
                    end
                end
                ST_PA:
                begin
                    if (k_reg != 2'd0)
                    begin
                        num_reg <= num_next;
                    end
                    state_reg <= ST_PB;
                end
                ST_PB:
                begin
                    a_reg     <= prod_reg[31:0];
                    state_reg <= ST_SQ;
                end
                ST_SQ:
                begin
                    if (k_reg == 2'd2)
                    begin
                        state_reg <= ST_SUMF;
                    end
                    else
                    begin
                        k_reg     <= k_reg + 2'd1;
                        state_reg <= ST_PA;
                    end
                end
                ST_SUMF:
                begin
                    num_reg   <= num_next;
                    rem_reg   <= 34'(num_next[65:35]);
                    q_reg     <= 35'd0;
                    cnt_reg   <= 6'd0;
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    rem_reg <= take ? 34'(trial - 35'(den_reg)) : trial[33:0];
                    q_reg   <= {q_reg[33:0], take};
                    num_reg <= {num_reg[64:0], 1'b0};
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'(DIV_STEPS - 1))
                    begin
                        dist_reg  <= {q_reg[33:0], take};
                        state_reg <= ST_CMP;
                    end
                end
                ST_CMP:
                begin
                    if (!have_b_reg || dist_reg < best_reg)
                    begin
                        if (have_b_reg)
                        begin
                            second_reg <= best_reg;
                            have_s_reg <= 1'b1;
                        end
                        best_reg   <= dist_reg;
                        have_b_reg <= 1'b1;
                        match_reg  <= 4'(ent_reg);
                    end
                    else if (!have_s_reg || dist_reg < second_reg)
                    begin
                        second_reg <= dist_reg;
                        have_s_reg <= 1'b1;
                    end
                    k_reg   <= 2'd0;
                    den_reg <= 34'd0;
                    if (ent_reg == CW'(NUM_COLORS - 1))
                    begin
                        state_reg <= ST_CHK;
                    end
                    else
                    begin
                        ent_reg   <= ent_reg + CW'(1);
                        state_reg <= ST_DEN;
                    end
                end
                ST_CHK, ST_G4:
                begin
                    if (state_reg == ST_CHK && have_s_reg && second_reg != 35'd0)
                    begin
                        state_reg <= ST_G1;
                    end
                    else if (!side_reg)
                    begin
                        lc_reg     <= side_color;
                        side_reg   <= 1'b1;
                        ent_reg    <= '0;
                        k_reg      <= 2'd0;
                        den_reg    <= 34'd0;
                        have_b_reg <= 1'b0;
                        have_s_reg <= 1'b0;
                        state_reg  <= ST_DEN;
                    end
                    else
                    begin
                        rc_reg    <= side_color;
                        state_reg <= ST_FIN;
                    end
                end
                ST_G1:
                begin
                    state_reg <= ST_G2;
                end
                ST_G2:
                begin
                    fail1_reg <= {best_reg, 16'd0} > prod_reg[50:0];
                    state_reg <= ST_G3;
                end
                ST_G3:
                begin
                    fail2_reg <= {35'(second_reg - best_reg), 16'd0} < prod_reg[50:0];
                    state_reg <= ST_G4;
                end
                ST_FIN:
                begin
                    if (!out_valid_reg || m_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                        out_reg       <= {1'b0, 5'(count_reg), 18'd0};
                        case (op_reg)
                            OP_CLEAR:
                            begin
                                count_reg <= '0;
                                last_reg  <= COLOR_NONE;
                                out_reg   <= '0;
                            end
                            OP_CLASSIFY:
                            begin
                                out_reg <= {1'b0, 5'(count_reg), CMD_NONE, 1'b0,
                                            4'd0, 1'b0, rc_reg, lc_reg};
                                if (lm == rm)
                                begin
                                    out_reg <= {1'b0, 5'(count_reg), CMD_NONE, 1'b0,
                                                lc_reg, 1'b1, rc_reg, lc_reg};
                                    if (lm == CMD_NONE)
                                    begin
                                        last_reg <= COLOR_NONE;
                                    end
                                    else if (5'(lc_reg) != last_reg)
                                    begin
                                        last_reg <= 5'(lc_reg);
                                        if (count_reg < NW'(CMD_CAPACITY))
                                        begin
                                            count_reg <= count_reg + NW'(1);
                                            out_reg <= {1'b0, 5'(count_reg + NW'(1)), lm,
                                                        1'b1, lc_reg, 1'b1, rc_reg, lc_reg};
                                        end
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== hdl/ccc_chk.sv =====
// Port-level checker for the colour card classifier, bound to the top level.
// Depends on ccc_pkg and color_card_classifier_core.
`timescale 1ns / 1ps

module ccc_chk
    import ccc_pkg::*;
#(
    parameter int CMD_CAPACITY = 16
)(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output item changed while stalled");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

    a_insert: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[13] |-> m_tdata[8] && m_tdata[17:14] != CMD_NONE)
        else $error("insert without agreement");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> 7'(m_tdata[22:18]) <= 7'(CMD_CAPACITY))
        else $error("command count beyond capacity");

endmodule

bind color_card_classifier_core ccc_chk #(.CMD_CAPACITY(CMD_CAPACITY)) u_ccc_chk (.*);

// ===== test/color_card_classifier_core_chk.sv =====
// Checker for the colour card classifier: follows the config port and both
// stream channels, predicts each result and compares it field by field.
// Depends on ccc_pkg for opcodes, register indexes, shade and command codes and port widths.
`timescale 1ns / 1ps

module color_card_classifier_core_chk
    import ccc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [2:0]            cfg_index,
    input  logic [CFG_W-1:0]      cfg_data,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [IN_USER_W-1:0]  s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    output int                    errors,
    output int                    pending
);

    localparam int NCOL = 12;
    localparam int CAP = 16;
    localparam logic [3:0] NO_COLOUR = 4'd12;

    typedef bit [2:0][15:0] rgb_t;

    localparam rgb_t HOME_RGB [NCOL] = '{
        {16'd900,  16'd900,  16'd900},  {16'd500,  16'd500,  16'd2000},
        {16'd450,  16'd1100, 16'd2200}, {16'd500,  16'd2000, 16'd2200},
        {16'd600,  16'd1800, 16'd500},  {16'd2000, 16'd700,  16'd500},
        {16'd1800, 16'd600,  16'd1200}, {16'd900,  16'd1900, 16'd1100},
        {16'd1900, 16'd1500, 16'd800},  {16'd1300, 16'd900,  16'd2100},
        {16'd200,  16'd200,  16'd200},  {16'd2200, 16'd2200, 16'd2200}
    };
    localparam bit [3:0] COLOUR_CMD [16] = '{
        4'd0, 4'd1, 4'd8, 4'd2, 4'd3, 4'd4, 4'd5, 4'd0,
        4'd7, 4'd6, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0
    };
    localparam int FLD_LSB [7] = '{0, 4, 8, 9, 13, 14, 18};
    localparam int FLD_W [7]   = '{4, 4, 1, 4, 1, 4, 5};
    localparam string FLD_NAME [7] = '{"left_color", "right_color", "agree_valid",
        "current_color", "new_command", "inserted_command", "command_count"};

    rgb_t       swatch [2][NCOL];
    bit [3:0]   prev_colour;
    bit [4:0]   cmd_count;
    bit [15:0]  ratio_lim, ratio_orange, ratio_yellow, ratio_green, margin_lim, chroma_lim;
    bit [17:0]  bright_lim;
    logic [OUT_DATA_W-1:0] expected_results [$];

    function automatic bit [63:0] residual_dist(rgb_t v, rgb_t r);
        bit [66:0] num;
        bit [33:0] den;
        bit [31:0] a, b;
        bit [63:0] df, sq;
        int j;
        num = 0;
        den = 0;
        for (int i = 0; i < 3; i++)
        begin
            j = (i + 1) % 3;
            a = v[i] * r[j];
            b = v[j] * r[i];
            df = (a > b) ? a - b : b - a;
            sq = df * df;
            num += sq;
            den += r[i] * r[i];
        end
        if (den == 0)
            return 64'(v[0]) * 64'(v[0]) + 64'(v[1]) * 64'(v[1]) + 64'(v[2]) * 64'(v[2]);
        return 64'(num / den);
    endfunction

    function automatic bit [3:0] nearest_colour(int sd, rgb_t v);
        bit [63:0] best, second, d;
        bit [95:0] lhs, rhs, lhs2, rhs2;
        bit [17:0] sum;
        bit [15:0] mx, mn, thr;
        bit have_best, have_second;
        bit [3:0] match;
        have_best = 0;
        have_second = 0;
        best = 0;
        second = 0;
        match = 0;
        for (int i = 0; i < NCOL; i++)
        begin
            d = residual_dist(v, swatch[sd][i]);
            if (!have_best || d < best)
            begin
                if (have_best)
                begin
                    second = best;
                    have_second = 1;
                end
                best = d;
                have_best = 1;
                match = 4'(i);
            end
            else if (!have_second || d < second)
            begin
                second = d;
                have_second = 1;
            end
        end
        if (!have_second || second == 0)
            return match;
        thr = (match == SHADE_ORANGE) ? ratio_orange : (match == SHADE_YELLOW) ? ratio_yellow
            : (match == SHADE_GREEN) ? ratio_green : ratio_lim;
        lhs = 96'(best) << 16;
        rhs = 96'(thr) * 96'(second);
        lhs2 = 96'(second - best) << 16;
        rhs2 = 96'(margin_lim) * 96'(second);
        if (lhs > rhs || lhs2 < rhs2)
        begin
            sum = 18'(v[0]) + 18'(v[1]) + 18'(v[2]);
            mx = v[0];
            mn = v[0];
            for (int k = 1; k < 3; k++)
            begin
                if (v[k] > mx) mx = v[k];
                if (v[k] < mn) mn = v[k];
            end
            if (sum < bright_lim || (48'(mx - mn) << 16) < 48'(chroma_lim) * 48'(sum))
                return SHADE_GRAY;
        end
        return match;
    endfunction

    function automatic logic [OUT_DATA_W-1:0] card_outcome(logic [1:0] op, bit sd,
                                                           bit [3:0] idx, rgb_t lv, rgb_t rv);
        logic [OUT_DATA_W-1:0] res;
        bit [3:0] lc, rc, lm, rm;
        res = '0;
        case (op)
            OP_WRITE:
            begin
                if (idx < NCOL)
                    swatch[sd][idx] = lv;
            end
            OP_CLEAR:
            begin
                cmd_count = 0;
                prev_colour = NO_COLOUR;
            end
            OP_CLASSIFY:
            begin
                lc = nearest_colour(0, lv);
                rc = nearest_colour(1, rv);
                lm = COLOUR_CMD[lc];
                rm = COLOUR_CMD[rc];
                res[3:0] = lc;
                res[7:4] = rc;
                if (lm == rm)
                begin
                    res[8] = 1'b1;
                    res[12:9] = lc;
                    if (lm == CMD_NONE)
                        prev_colour = NO_COLOUR;
                    else if (lc != prev_colour)
                    begin
                        prev_colour = lc;
                        if (cmd_count < CAP)
                        begin
                            cmd_count++;
                            res[13] = 1'b1;
                            res[17:14] = lm;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        res[22:18] = cmd_count;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rgb_t lv, rv;
        logic [OUT_DATA_W-1:0] want;
        if (!rst_n)
        begin
            for (int s = 0; s < 2; s++)
                for (int i = 0; i < NCOL; i++)
                    swatch[s][i] = HOME_RGB[i];
            prev_colour = NO_COLOUR;
            cmd_count = 0;
            ratio_lim = 16'd55706;
            ratio_orange = 16'd60293;
            ratio_yellow = 16'd60293;
            ratio_green = 16'd58982;
            margin_lim = 16'd3277;
            bright_lim = 18'd150;
            chroma_lim = 16'd1311;
            expected_results.delete();
            errors <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_RATIO:        ratio_lim = cfg_data[15:0];
                    REG_RATIO_ORANGE: ratio_orange = cfg_data[15:0];
                    REG_RATIO_YELLOW: ratio_yellow = cfg_data[15:0];
                    REG_RATIO_GREEN:  ratio_green = cfg_data[15:0];
                    REG_MARGIN:       margin_lim = cfg_data[15:0];
                    REG_BRIGHT:       bright_lim = cfg_data[17:0];
                    REG_CHROMA:       chroma_lim = cfg_data[15:0];
                    default:
                    begin
                    end
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: result %h with nothing expected", $time, m_tdata);
                    errors <= errors + 1;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (want !== m_tdata)
                    begin
                        for (int f = 0; f < 7; f++)
                            if ((want >> FLD_LSB[f]) % (1 << FLD_W[f]) !==
                                (m_tdata >> FLD_LSB[f]) % (1 << FLD_W[f]))
                                $display("%0t: %s expected %0d actual %0d", $time, FLD_NAME[f],
                                         (want >> FLD_LSB[f]) % (1 << FLD_W[f]),
                                         (m_tdata >> FLD_LSB[f]) % (1 << FLD_W[f]));
                        errors <= errors + 1;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    lv[k] = s_tdata[4 + 16 * k +: 16];
                    rv[k] = s_tdata[52 + 16 * k +: 16];
                end
                expected_results.push_back(card_outcome(s_tuser[1:0], s_tuser[2],
                                                        s_tdata[3:0], lv, rv));
            end
            pending <= expected_results.size();
        end
    end

endmodule

// ===== test/color_card_classifier_core_tb.sv =====
// Testbench top for the colour card classifier: drives reference writes, classify,
// clear and unused items under changing thresholds with random gaps and output stalls.
// Depends on ccc_pkg, color_card_classifier_core and its checker.
`timescale 1ns / 1ps

module color_card_classifier_core_tb;
    import ccc_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [2:0] REG_NONE = 3'd7;
    localparam int IDLE_LIMIT = 30000;
    localparam int PHASE_ITEMS = 300;

    typedef bit [2:0][15:0] rgb_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [2:0]            cfg_index = '0;
    logic [CFG_W-1:0]      cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [IN_USER_W-1:0]  s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    int                    errors;
    int                    pending;
    int                    idle_cycles = 0;
    int                    stall_left = 0;
    bit                    calm = 1'b0;
    rgb_t                  ref_copy [2][12];

    color_card_classifier_core uut (
        .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    color_card_classifier_core_chk chk (
        .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .errors(errors), .pending(pending)
    );

    always #5 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(20, 150);
    endfunction

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            stall_left <= pick_gap();
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("color_card_classifier_core_tb NOT OK");
                $finish;
            end
        end
    end

    task automatic send_item(logic [1:0] op, bit sd, bit [3:0] idx, rgb_t lv, rgb_t rv);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= {sd, op};
        s_tdata <= {4'd0, rv[2], rv[1], rv[0], lv[2], lv[1], lv[0], idx};
        do
            @(posedge clk);
        while (!s_tready);
        if (op == OP_WRITE && idx < 12)
            ref_copy[sd][idx] = lv;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    // mode 0 defaults, 1 all zero, 2 all maximum, otherwise random
    task automatic apply_thresholds(int mode);
        logic [17:0] v [7];
        v = '{18'd55706, 18'd60293, 18'd60293, 18'd58982, 18'd3277, 18'd150, 18'd1311};
        for (int i = 0; i < 7; i++)
        begin
            if (mode == 1)
                v[i] = 18'd0;
            else if (mode == 2)
                v[i] = (i == REG_BRIGHT) ? 18'd196605 : 18'd65535;
            else if (mode >= 3)
                v[i] = (i == REG_BRIGHT) ? 18'($urandom_range(0, 196605))
                     : (i == REG_MARGIN || i == REG_CHROMA) ? 18'($urandom_range(0, 8000))
                     : 18'($urandom_range(40000, 65535));
        end
        wait_drained();
        write_reg(REG_RATIO, v[0]);
        write_reg(REG_RATIO_ORANGE, v[1]);
        write_reg(REG_RATIO_YELLOW, v[2]);
        write_reg(REG_RATIO_GREEN, v[3]);
        write_reg(REG_MARGIN, v[4]);
        write_reg(REG_BRIGHT, v[5]);
        write_reg(REG_CHROMA, v[6]);
        write_reg(REG_NONE, 18'($urandom_range(0, 262143)));
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    function automatic rgb_t noise_rgb();
        rgb_t v;
        for (int k = 0; k < 3; k++)
            v[k] = 16'($urandom_range(0, 65535));
        return v;
    endfunction

    // scaled, jittered copy of a known reference colour
    function automatic rgb_t near_colour(bit sd, int c);
        rgb_t v;
        int k4, x;
        k4 = $urandom_range(1, 12);
        for (int k = 0; k < 3; k++)
        begin
            x = ref_copy[sd][c][k] * k4 / 4 + $urandom_range(0, 60) - 30;
            v[k] = (x < 0) ? 16'd0 : (x > 65535) ? 16'hFFFF : x[15:0];
        end
        return v;
    endfunction

    task automatic random_item();
        int r, c;
        rgb_t a;
        r = $urandom_range(0, 99);
        c = $urandom_range(0, 11);
        if (r < 55)
            send_item(OP_CLASSIFY, 1'b0, 4'd0, near_colour(1'b0, c),
                      near_colour(1'b1, ($urandom_range(0, 4) == 0) ? $urandom_range(0, 11) : c));
        else if (r < 70)
            send_item(OP_CLASSIFY, 1'($urandom), 4'($urandom), noise_rgb(), noise_rgb());
        else if (r < 85)
        begin
            a = ($urandom_range(0, 9) == 0) ? '0 : near_colour(1'($urandom_range(0, 1)), c);
            send_item(OP_WRITE, 1'($urandom), 4'($urandom_range(0, 12)), a, noise_rgb());
        end
        else if (r < 88)
            send_item(OP_WRITE, 1'($urandom), 4'($urandom), noise_rgb(), noise_rgb());
        else if (r < 91)
            send_item(OP_WRITE, 1'($urandom), 4'(c), {ccc_pkg::default_rgb(4'(c), 2'd2),
                      ccc_pkg::default_rgb(4'(c), 2'd1), ccc_pkg::default_rgb(4'(c), 2'd0)}, a);
        else if (r < 96)
            send_item(OP_CLEAR, 1'($urandom), 4'($urandom), noise_rgb(), noise_rgb());
        else
            send_item(OP_UNUSED, 1'($urandom), 4'($urandom), noise_rgb(), noise_rgb());
    endtask

    initial
    begin
        rgb_t z, top;
        z = '0;
        top = {16'hFFFF, 16'hFFFF, 16'hFFFF};
        for (int s = 0; s < 2; s++)
            for (int c = 0; c < 12; c++)
                for (int k = 0; k < 3; k++)
                    ref_copy[s][c][k] = ccc_pkg::default_rgb(4'(c), 2'(k));
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: fill the list to capacity, extremes, zero reference
        for (int i = 0; i < 18; i++)
            send_item(OP_CLASSIFY, 1'b0, 4'd0, ref_copy[0][1 + i % 9], ref_copy[1][1 + i % 9]);
        send_item(OP_CLASSIFY, 1'b0, 4'd0, z, z);
        send_item(OP_CLASSIFY, 1'b1, 4'hF, top, top);
        send_item(OP_CLEAR, 1'b0, 4'd0, z, z);
        send_item(OP_UNUSED, 1'b1, 4'hF, top, top);
        send_item(OP_WRITE, 1'b1, 4'd15, top, top);
        send_item(OP_WRITE, 1'b0, 4'd10, z, z);
        send_item(OP_CLASSIFY, 1'b0, 4'd0, ref_copy[0][3], ref_copy[1][3]);
        send_item(OP_WRITE, 1'b0, 4'd10, ref_copy[1][10], z);

        for (int p = 0; p < 6; p++)
        begin
            apply_thresholds((p + 1) % 5);
            calm = (p == 2);
            for (int i = 0; i < PHASE_ITEMS; i++)
                random_item();
        end
        calm = 1'b0;
        wait_drained();
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("color_card_classifier_core_tb OK");
        else
            $display("color_card_classifier_core_tb NOT OK");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/ccc_pkg.sv
hdl/color_card_classifier_core.sv
hdl/ccc_chk.sv
test/color_card_classifier_core_chk.sv
test/color_card_classifier_core_tb.sv
